FILE: sv/sjd_pkg.sv
// ----------------------------------------------------------------------------
// sjd_pkg
// Shared types, codes and tables for the Shift-JIS to JIS decoder.
// ----------------------------------------------------------------------------
package sjd_pkg;

	// Variant register codes
	localparam logic [1:0] VAR_MS    = 2'd0;
	localparam logic [1:0] VAR_APPLE = 2'd1;
	localparam logic [1:0] VAR_X0213 = 2'd2;

	// Charset codes of a result item
	localparam logic [3:0] CS_ASCII  = 4'd0;
	localparam logic [3:0] CS_KANA   = 4'd1;
	localparam logic [3:0] CS_X0208  = 4'd2;
	localparam logic [3:0] CS_MAC    = 4'd3;
	localparam logic [3:0] CS_NEC    = 4'd4;
	localparam logic [3:0] CS_NECIBM = 4'd5;
	localparam logic [3:0] CS_IBM    = 4'd6;
	localparam logic [3:0] CS_P1     = 4'd7;
	localparam logic [3:0] CS_P2     = 4'd8;

	// Status codes
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_INVALID = 1'b1;

	// Configuration register map
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned REG_VARIANT = 0;

	// Queue between front and back
	localparam int unsigned QDEPTH  = 2;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	// Classified item handed from front to back
	typedef struct packed {
		logic       pair;     // two-byte item
		logic [3:0] charset;  // class of the item
		logic [7:0] c1;       // single char or lead byte
		logic [7:0] c2;       // trail byte, zero when single
	} tok_t;

	// Result item
	typedef struct packed {
		logic [3:0] charset;
		logic [7:0] code_first;
		logic [7:0] code_second;
		logic [1:0] code_width;
		logic       status;
	} res_t;

	// Plane 2 row for trail bytes up to 0x9E
	function automatic logic [7:0] p2_row_low(input logic [3:0] k);
		logic [7:0] r;
		case (k)
			4'd0:    r = 8'h21;
			4'd1:    r = 8'h23;
			4'd2:    r = 8'h25;
			4'd3:    r = 8'h2d;
			4'd4:    r = 8'h2f;
			4'd5:    r = 8'h6f;
			4'd6:    r = 8'h71;
			4'd7:    r = 8'h73;
			4'd8:    r = 8'h75;
			4'd9:    r = 8'h77;
			4'd10:   r = 8'h79;
			4'd11:   r = 8'h7b;
			4'd12:   r = 8'h7d;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Plane 2 row for trail bytes above 0x9E
	function automatic logic [7:0] p2_row_high(input logic [3:0] k);
		logic [7:0] r;
		case (k)
			4'd0:    r = 8'h28;
			4'd1:    r = 8'h24;
			4'd2:    r = 8'h2c;
			4'd3:    r = 8'h2e;
			4'd4:    r = 8'h6e;
			4'd5:    r = 8'h70;
			4'd6:    r = 8'h72;
			4'd7:    r = 8'h74;
			4'd8:    r = 8'h76;
			4'd9:    r = 8'h78;
			4'd10:   r = 8'h7a;
			4'd11:   r = 8'h7c;
			4'd12:   r = 8'h7e;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/sjd_if.sv
// ----------------------------------------------------------------------------
// sjd_if
// Valid/ready channels of the decoder: raw byte in, decoded result out.
// ----------------------------------------------------------------------------
interface sjd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface sjd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] charset;
	logic [7:0] code_first;
	logic [7:0] code_second;
	logic [1:0] code_width;
	logic       status;

	modport source (output valid, output charset, output code_first, output code_second,
		output code_width, output status, input ready);
	modport sink (input valid, input charset, input code_first, input code_second,
		input code_width, input status, output ready);
endinterface

FILE: sv/sjd_front.sv
// ----------------------------------------------------------------------------
// sjd_front
// Accepts stream bytes, tracks the pending lead byte and classes each item.
// ----------------------------------------------------------------------------
module sjd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    variant,
	sjd_in_if.sink        in_ch,
	input  logic          q_full,
	output logic          push,
	output sjd_pkg::tok_t push_tok
);
	import sjd_pkg::*;

	logic        lead_q;
	logic [7:0]  lead_byte_q;
	logic        take;
	logic        is_single;
	logic [7:0]  b;
	logic [15:0] code;
	logic [3:0]  pair_cs;

	assign b            = in_ch.in_byte;
	assign in_ch.ready  = !q_full;
	assign take         = in_ch.valid && in_ch.ready;
	assign is_single    = (b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hDF);
	assign code         = {lead_byte_q, b};
	assign push         = take && (lead_q || is_single);

	// Class of a completed pair by variant
	always_comb begin
		pair_cs = CS_X0208;
		case (variant)
			VAR_X0213: begin
				pair_cs = (lead_byte_q >= 8'hF0) ? CS_P2 : CS_P1;
			end
			VAR_APPLE: begin
				if ((code >= 16'h8540 && code <= 16'h886d) ||
				    (code >= 16'heb41 && code <= 16'hed96))
					pair_cs = CS_MAC;
			end
			default: begin
				if (code >= 16'h8740 && code <= 16'h879c)
					pair_cs = CS_NEC;
				else if (code >= 16'hed40 && code <= 16'heefc)
					pair_cs = CS_NECIBM;
				else if (code >= 16'hfa40 && code <= 16'hfc4b)
					pair_cs = CS_IBM;
			end
		endcase
	end

	// Item handed to the queue
	always_comb begin
		if (lead_q) begin
			push_tok = '{pair: 1'b1, charset: pair_cs, c1: lead_byte_q, c2: b};
		end else if (b <= 8'h7E) begin
			push_tok = '{pair: 1'b0, charset: CS_ASCII, c1: b, c2: 8'h00};
		end else begin
			push_tok = '{pair: 1'b0, charset: CS_KANA, c1: {1'b0, b[6:0]}, c2: 8'h00};
		end
	end

	// Lead byte tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q      <= 1'b0;
			lead_byte_q <= 8'h00;
		end else if (take) begin
			if (lead_q) begin
				lead_q <= 1'b0;
			end else if (!is_single) begin
				lead_q      <= 1'b1;
				lead_byte_q <= b;
			end
		end
	end

endmodule

FILE: sv/sjd_queue.sv
// ----------------------------------------------------------------------------
// sjd_queue
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module sjd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sjd_pkg::tok_t push_tok,
	output logic          full,
	input  logic          pop,
	output sjd_pkg::tok_t pop_tok,
	output logic          nonempty
);
	import sjd_pkg::*;

	tok_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_tok  = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_tok;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: sv/sjd_back.sv
// ----------------------------------------------------------------------------
// sjd_back
// Converts non-IBM pairs to JIS row/cell and holds the result register.
// ----------------------------------------------------------------------------
module sjd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  sjd_pkg::tok_t tok,
	output logic          pop,
	sjd_out_if.source     out_ch
);
	import sjd_pkg::*;

	logic       out_valid_q;
	res_t       res_q;
	res_t       res;

	assign pop = q_valid && (!out_valid_q || out_ch.ready);

	// Conversion of one item
	always_comb begin
		logic [7:0] hi;
		logic [7:0] lo;
		logic       bad;
		hi  = 8'h00;
		lo  = 8'h00;
		bad = 1'b0;
		if (!tok.pair) begin
			res = '{charset: tok.charset, code_first: tok.c1, code_second: 8'h00,
				code_width: 2'd1, status: ST_OK};
		end else if (tok.charset == CS_IBM) begin
			res = '{charset: CS_IBM, code_first: tok.c1, code_second: tok.c2,
				code_width: 2'd2, status: ST_OK};
		end else begin
			if (tok.charset == CS_P2) begin
				// Plane 2: lead 0xF0..0xFC, trail unchecked
				bad = (tok.c1 > 8'hFC);
				if (tok.c2 <= 8'h9E) begin
					hi = p2_row_low(tok.c1[3:0]);
					lo = (tok.c2 > 8'h7E) ? tok.c2 - 8'h20 : tok.c2 - 8'h1F;
				end else begin
					hi = p2_row_high(tok.c1[3:0]);
					lo = tok.c2 - 8'h7E;
				end
			end else begin
				// Row from lead byte
				if (tok.c1 >= 8'h81 && tok.c1 <= 8'h9F)
					hi = tok.c1 - 8'h71;
				else if (tok.c1 >= 8'hE0 && tok.c1 <= 8'hFC)
					hi = tok.c1 - 8'hB1;
				else
					bad = 1'b1;
				hi = {hi[6:0], 1'b1};
				// Cell from trail byte, skipping 0x7F
				lo = (tok.c2 >= 8'h80) ? tok.c2 - 8'h01 : tok.c2;
				if (lo >= 8'h9E && lo <= 8'hFB) begin
					lo = lo - 8'h7D;
					hi = hi + 8'h01;
				end else if (lo >= 8'h40 && lo <= 8'h9D) begin
					lo = lo - 8'h1F;
				end else begin
					bad = 1'b1;
				end
			end
			if (bad)
				res = '{charset: CS_ASCII, code_first: tok.c1, code_second: tok.c2,
					code_width: 2'd2, status: ST_INVALID};
			else
				res = '{charset: tok.charset, code_first: hi, code_second: lo,
					code_width: 2'd2, status: ST_OK};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= res;
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.charset     = res_q.charset;
	assign out_ch.code_first  = res_q.code_first;
	assign out_ch.code_second = res_q.code_second;
	assign out_ch.code_width  = res_q.code_width;
	assign out_ch.status      = res_q.status;

	// An invalid pair always reports the ascii charset and two bytes
	a_invalid_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status == ST_INVALID |->
			res_q.charset == CS_ASCII && res_q.code_width == 2'd2)
		else $error("invalid result with wrong shape");

	// Single-byte results carry no second byte and only ascii or kana
	a_single_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.code_width == 2'd1 |->
			res_q.code_second == 8'h00 &&
			(res_q.charset == CS_ASCII || res_q.charset == CS_KANA))
		else $error("single result with wrong shape");

	// Never pop from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop without queued item");

endmodule

FILE: sv/shift_jis_to_jis_decoder_top.sv
// ----------------------------------------------------------------------------
// shift_jis_to_jis_decoder_top
// Shift-JIS byte stream to ASCII, kana and JIS row/cell decoder.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock on in_ch while its queue is not full,
// and gives at most one result per byte on out_ch. Single bytes (ASCII,
// half-width kana) each give a result; a lead byte is held and gives
// nothing, and the following byte gives the pair's result. A taken byte is
// written into the front-to-back queue, then its result is loaded into the
// output register, where it waits until out_ch takes it; the load waits
// while the output register holds a result that out_ch has not taken. The
// two-entry queue lets the input keep taking bytes while a result waits on
// out_ch. The variant register (offset 0x0) selects Microsoft, Apple or JIS
// X0213 classing; write it only while the decoder is idle.
module shift_jis_to_jis_decoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sjd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	sjd_in_if.sink                      in_ch,
	sjd_out_if.source                   out_ch
);
	import sjd_pkg::*;

	logic [1:0] variant_q;
	logic       cfg_wr;
	logic       reg_hit;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_valid;
	tok_t       push_tok;
	tok_t       pop_tok;

	// Register access
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1] == 1'(REG_VARIANT));
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? {30'd0, variant_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VAR_MS;
		end else if (cfg_wr) begin
			variant_q <= pwdata[1:0];
		end
	end

	sjd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.variant  (variant_q),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (push),
		.push_tok (push_tok)
	);

	sjd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.full     (q_full),
		.pop      (pop),
		.pop_tok  (pop_tok),
		.nonempty (q_valid)
	);

	sjd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.tok     (pop_tok),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule
